[hw/rtl/pollard_rho_factor_finder_assert.svh]
// ----------------------------------------------------------------------------
// Pollard rho factor finder assertion macros
// Shared macros for the concurrent checks of the factor finder.
// ----------------------------------------------------------------------------
`ifndef POLLARD_RHO_FACTOR_FINDER_ASSERT_SVH
`define POLLARD_RHO_FACTOR_FINDER_ASSERT_SVH

// Checks a property on every rising edge of clk outside reset.
`define PRF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("factor finder check failed");

// Same check with a caller-chosen message.
`define PRF_ASSERT_MSG(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

[hw/rtl/prf_pkg.sv]
// ----------------------------------------------------------------------------
// Pollard rho factor finder package
// Request and response types, status codes and the modular add helper.
// ----------------------------------------------------------------------------
package prf_pkg;

  localparam int NUM_W = 62;
  localparam int RND_W = 32;
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [1:0] STAT_FOUND   = 2'd0;
  localparam logic [1:0] STAT_RETRY   = 2'd1;
  localparam logic [1:0] STAT_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [NUM_W-1:0] modulus;
    logic [NUM_W-1:0] start_value;
    logic [NUM_W-1:0] increment;
  } prf_req_t;

  typedef struct packed {
    logic [NUM_W-1:0] factor;
    logic [1:0]       status;
    logic [RND_W-1:0] rounds_used;
  } prf_resp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } prf_mul_stat_t;

  // Sum of two residues below n, reduced once.
  function automatic logic [NUM_W-1:0] add_mod(input logic [NUM_W-1:0] a,
                                               input logic [NUM_W-1:0] b,
                                               input logic [NUM_W-1:0] n);
    logic [NUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) begin
      s = s - {1'b0, n};
    end
    return s[NUM_W-1:0];
  endfunction

endpackage

[hw/rtl/prf_mulmod.sv]
// ----------------------------------------------------------------------------
// Modular multiplier
// Shift-and-add product of two residues modulo n, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module prf_mulmod (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [prf_pkg::NUM_W-1:0] op_a,
  input  logic [prf_pkg::NUM_W-1:0] op_b,
  input  logic [prf_pkg::NUM_W-1:0] modulus,
  output logic [prf_pkg::NUM_W-1:0] product,
  output prf_pkg::prf_mul_stat_t   stat
);
  import prf_pkg::*;

  logic             busy_r, busy_nxt;
  logic [NUM_W-1:0] acc_r, acc_nxt;
  logic [NUM_W-1:0] addend_r, addend_nxt;
  logic [NUM_W-1:0] mbits_r, mbits_nxt;
  logic             finish;

  assign finish       = busy_r && (mbits_r == '0);
  assign stat.busy    = busy_r;
  assign stat.done    = finish;
  assign product      = acc_r;

  always_comb begin
    busy_nxt   = busy_r;
    acc_nxt    = acc_r;
    addend_nxt = addend_r;
    mbits_nxt  = mbits_r;
    if (start) begin
      busy_nxt   = 1'b1;
      acc_nxt    = '0;
      addend_nxt = op_a;
      mbits_nxt  = op_b;
    end else if (finish) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      if (mbits_r[0]) begin
        acc_nxt = add_mod(acc_r, addend_r, modulus);
      end
      addend_nxt = add_mod(addend_r, addend_r, modulus);
      mbits_nxt  = mbits_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    acc_r    <= acc_nxt;
    addend_r <= addend_nxt;
    mbits_r  <= mbits_nxt;
  end

endmodule

[hw/rtl/pollard_rho_factor_finder.sv]
// ----------------------------------------------------------------------------
// Pollard rho factor finder
// Searches for a divisor of n with the rho iteration and Floyd cycle finding.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the response appears on out_resp with a one-cycle out_valid strobe,
// which the receiver must take in that cycle. An even n is answered with the
// factor 2. Otherwise seed and increment are reduced bit-serially. Each round
// then runs three modular squarings on the shared shift-and-add multiplier
// plus a binary gcd.
module pollard_rho_factor_finder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_start,
  input  prf_pkg::prf_req_t         in_req,
  output logic                      busy,
  output logic                      out_valid,
  output prf_pkg::prf_resp_t        out_resp,
  input  logic                      cfg_we,
  input  logic [prf_pkg::RND_W-1:0] cfg_wdata
);
  import prf_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EVEN   = 3'd1;
  localparam logic [2:0] ST_RED    = 3'd2;
  localparam logic [2:0] ST_CHECK  = 3'd3;
  localparam logic [2:0] ST_MSTART = 3'd4;
  localparam logic [2:0] ST_MWAIT  = 3'd5;
  localparam logic [2:0] ST_GCD    = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [NUM_W-1:0] n_r, n_nxt;
  logic [NUM_W-1:0] tort_r, tort_nxt;
  logic [NUM_W-1:0] hare_r, hare_nxt;
  logic [NUM_W-1:0] offs_r, offs_nxt;
  logic [NUM_W-1:0] src_r, src_nxt;
  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rsel_r, rsel_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic [NUM_W-1:0] ga_r, ga_nxt;
  logic [NUM_W-1:0] gb_r, gb_nxt;
  logic [RND_W-1:0] maxr_r;
  logic             out_valid_r, out_valid_nxt;
  prf_resp_t        out_resp_r, out_resp_nxt;

  logic             mul_start;
  logic [NUM_W-1:0] mul_x;
  logic [NUM_W-1:0] mul_res;
  prf_mul_stat_t    mul_stat;

  prf_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_x),
    .op_b    (mul_x),
    .modulus (n_r),
    .product (mul_res),
    .stat    (mul_stat)
  );

  assign mul_x     = (step_r == 2'd0) ? tort_r : hare_r;
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_resp  = out_resp_r;

  always_comb begin
    logic [NUM_W:0]   t;
    logic [NUM_W-1:0] red;
    logic [NUM_W-1:0] newx;
    logic [NUM_W-1:0] t_next;
    logic [NUM_W-1:0] h_next;
    logic [NUM_W-1:0] diff;
    state_nxt     = state_r;
    n_nxt         = n_r;
    tort_nxt      = tort_r;
    hare_nxt      = hare_r;
    offs_nxt      = offs_r;
    src_nxt       = src_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    rsel_nxt      = rsel_r;
    step_nxt      = step_r;
    rnd_nxt       = rnd_r;
    ga_nxt        = ga_r;
    gb_nxt        = gb_r;
    out_valid_nxt = 1'b0;
    out_resp_nxt  = out_resp_r;
    mul_start     = 1'b0;
    t             = {rem_r, src_r[NUM_W-1]};
    if (t >= {1'b0, n_r}) begin
      t = t - {1'b0, n_r};
    end
    red    = t[NUM_W-1:0];
    newx   = add_mod(mul_res, offs_r, n_r);
    t_next = (step_r == 2'd0) ? newx : tort_r;
    h_next = (step_r == 2'd0) ? hare_r : newx;
    diff   = (t_next >= h_next) ? t_next - h_next : h_next - t_next;
    unique case (state_r)
      ST_IDLE: begin
        if (in_start) begin
          n_nxt    = in_req.modulus;
          rnd_nxt  = '0;
          src_nxt  = in_req.start_value;
          offs_nxt = in_req.increment;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          rsel_nxt = 1'b0;
          state_nxt = in_req.modulus[0] ? ST_RED : ST_EVEN;
        end
      end
      ST_EVEN: begin
        out_valid_nxt            = 1'b1;
        out_resp_nxt.factor      = NUM_W'(2);
        out_resp_nxt.status      = STAT_FOUND;
        out_resp_nxt.rounds_used = '0;
        state_nxt                = ST_IDLE;
      end
      ST_RED: begin
        rem_nxt = red;
        src_nxt = src_r << 1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          cnt_nxt = '0;
          if (!rsel_r) begin
            tort_nxt = red;
            hare_nxt = red;
            src_nxt  = offs_r;
            rem_nxt  = '0;
            rsel_nxt = 1'b1;
          end else begin
            offs_nxt  = red;
            state_nxt = ST_CHECK;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_CHECK: begin
        if (rnd_r >= maxr_r) begin
          out_valid_nxt            = 1'b1;
          out_resp_nxt.factor      = '0;
          out_resp_nxt.status      = STAT_TIMEOUT;
          out_resp_nxt.rounds_used = rnd_r;
          state_nxt                = ST_IDLE;
        end else begin
          step_nxt  = 2'd0;
          state_nxt = ST_MSTART;
        end
      end
      ST_MSTART: begin
        mul_start = 1'b1;
        state_nxt = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (mul_stat.done) begin
          tort_nxt = t_next;
          hare_nxt = h_next;
          if (step_r == 2'd2) begin
            rnd_nxt = rnd_r + 1'b1;
            if (diff == '0) begin
              out_valid_nxt            = 1'b1;
              out_resp_nxt.factor      = '0;
              out_resp_nxt.status      = STAT_RETRY;
              out_resp_nxt.rounds_used = rnd_r + 1'b1;
              state_nxt                = ST_IDLE;
            end else begin
              ga_nxt    = diff;
              gb_nxt    = n_r;
              state_nxt = ST_GCD;
            end
          end else begin
            step_nxt  = step_r + 1'b1;
            state_nxt = ST_MSTART;
          end
        end
      end
      ST_GCD: begin
        if (!ga_r[0]) begin
          ga_nxt = ga_r >> 1;
        end else if (ga_r == gb_r) begin
          if (ga_r == n_r) begin
            out_valid_nxt            = 1'b1;
            out_resp_nxt.factor      = '0;
            out_resp_nxt.status      = STAT_RETRY;
            out_resp_nxt.rounds_used = rnd_r;
            state_nxt                = ST_IDLE;
          end else if (ga_r != NUM_W'(1)) begin
            out_valid_nxt            = 1'b1;
            out_resp_nxt.factor      = ga_r;
            out_resp_nxt.status      = STAT_FOUND;
            out_resp_nxt.rounds_used = rnd_r;
            state_nxt                = ST_IDLE;
          end else begin
            state_nxt = ST_CHECK;
          end
        end else if (ga_r > gb_r) begin
          ga_nxt = ga_r - gb_r;
        end else begin
          ga_nxt = gb_r - ga_r;
          gb_nxt = ga_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      maxr_r      <= RND_W'(1048576);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        maxr_r <= cfg_wdata;
      end
    end
    n_r        <= n_nxt;
    tort_r     <= tort_nxt;
    hare_r     <= hare_nxt;
    offs_r     <= offs_nxt;
    src_r      <= src_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    rsel_r     <= rsel_nxt;
    step_r     <= step_nxt;
    rnd_r      <= rnd_nxt;
    ga_r       <= ga_nxt;
    gb_r       <= gb_nxt;
    out_resp_r <= out_resp_nxt;
  end

endmodule

[hw/rtl/prf_checker.sv]
// ----------------------------------------------------------------------------
// Pollard rho factor finder checker
// Port-level checks of request and response timing and of response contents,
// bound to the top level.
`include "pollard_rho_factor_finder_assert.svh"

module prf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_start,
  input logic               busy,
  input logic               out_valid,
  input prf_pkg::prf_resp_t out_resp
);
  import prf_pkg::*;

  `PRF_ASSERT(a_accept_busy, in_start && !busy |=> busy)
  `PRF_ASSERT(a_strobe_single, out_valid |=> !out_valid)
  `PRF_ASSERT(a_end_has_resp, $fell(busy) |-> out_valid)
  `PRF_ASSERT_MSG(a_fail_no_factor,
    out_valid && (out_resp.status != STAT_FOUND) |-> (out_resp.factor == '0),
    "factor reported with a failure status")
  `PRF_ASSERT_MSG(a_status_code,
    out_valid |-> ((out_resp.status == STAT_FOUND) || (out_resp.status == STAT_RETRY) ||
                   (out_resp.status == STAT_TIMEOUT)), "undefined status code")

endmodule

bind pollard_rho_factor_finder prf_checker u_prf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_start  (in_start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_resp  (out_resp)
);
